[rtl/lpht_pkg.sv]
// Shared constants, codes and types for the linear probing hash table.
// No dependencies; compiled first.
package lpht_pkg;

   // Fixed field widths of the request and response beats
   localparam int CMD_W         = 2;
   localparam int KEY_IN_W      = 32;
   localparam int STATUS_W      = 2;
   localparam int SLOT_INDEX_W  = 4;
   localparam int PROBE_COUNT_W = 5;
   localparam int MARK_W        = 2;

   // Parameter defaults
   localparam int DEF_SLOTS    = 16;
   localparam int DEF_KEY_BITS = 32;

   // Commands
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   // Slot marks
   localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
   localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
   localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

   // Response status
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // Write strobes into the slot store
   typedef struct packed {
      logic              key_we;
      logic              mark_we;
      logic [MARK_W-1:0] mark;
   } lpht_wr_type;

endpackage

[rtl/lpht_if.sv]
// Request and response channel interfaces (valid/ready plus payload).
// Depends on lpht_pkg.
interface lpht_req_if import lpht_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [KEY_IN_W-1:0] key;

   modport source (output valid, output cmd, output key, input ready);
   modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [SLOT_INDEX_W-1:0]  slot_index;
   logic [PROBE_COUNT_W-1:0] probe_count;

   modport source (output valid, output status, output slot_index, output probe_count,
                   input ready);
   modport sink   (input valid, input status, input slot_index, input probe_count,
                   output ready);
endinterface

[rtl/linear_probe_hash_table.sv]
// Linear probing hash table, top level: probe sequencer around the slot store.
// Depends on lpht_pkg, lpht_if, lpht_hash and lpht_store.
//
// Open-addressing table of SLOTS slots. Each request beat is one insert, find or
// delete of a key (reduced to its low KEY_BITS bits); each produces exactly one
// response beat with status, slot index and probe count. The home slot is the
// key modulo SLOTS; probing walks forward with wrap and visits at most SLOTS
// slots, reporting a full table (insert) or a miss (find/delete) when it runs
// out. Deleted slots become tombstones: insert reuses them, lookups skip them.
// Keys and marks live in two single-port-read memories with registered read
// data; one slot is examined per cycle while the output register is free. An
// item is set up by the accept, then two home-slot stages (the second issuing
// the first read), and then walks one slot after another; in the worst case
// the probe walk through the mark/key memory read port sets the time from one
// accept to the next. One item is in flight at a time; a new request beat is
// taken while the previous response beat still waits in the output register,
// and probing holds on its current slot for as long as that register stays
// occupied. After reset the mark memory is swept to empty, one slot a cycle,
// through all SLOTS slots; no request beat is accepted during the sweep.
module linear_probe_hash_table import lpht_pkg::*; #(
   parameter int SLOTS    = DEF_SLOTS,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic       clock,
   input  logic       reset,
   lpht_req_if.sink   req_bus,
   lpht_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int KEY_W = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
   localparam logic [KEY_IN_W-1:0]      KEY_MASK   = KEY_IN_W'((64'd1 << KEY_W) - 64'd1);
   localparam logic [IDX_W-1:0]         LAST_IDX   = IDX_W'(SLOTS - 1);
   localparam logic [PROBE_COUNT_W-1:0] FULL_COUNT = PROBE_COUNT_W'(SLOTS);

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_HASH  = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [IDX_W-1:0]        probe_idx_ff, probe_idx_in;
   logic [IDX_W-1:0]        step_ff, step_in;

   // Response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [SLOT_INDEX_W-1:0]  slot_ff, slot_in;
   logic [PROBE_COUNT_W-1:0] count_ff, count_in;

   logic                    req_accept;
   logic                    out_busy;
   logic [KEY_IN_W-1:0]     key_masked;
   logic                    home_valid;
   logic [IDX_W-1:0]        home;
   logic                    clear_busy;
   logic [IDX_W-1:0]        rd_addr;
   logic [KEY_W-1:0]        rd_key;
   logic [MARK_W-1:0]       rd_mark;
   lpht_wr_type             wr;

   logic                    is_insert, is_lookup, bad_cmd;
   logic                    ins_hit, lk_hit, lk_miss, last_step;
   logic [IDX_W+SLOT_INDEX_W-1:0]  slot_ext;
   logic [IDX_W+PROBE_COUNT_W-1:0] step_ext;

   assign key_masked = req_bus.key & KEY_MASK;
   assign req_bus.ready = (state_ff == ST_IDLE) && !clear_busy;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign out_busy      = rsp_valid_ff && !rsp_bus.ready;

   lpht_hash #(
      .SLOTS (SLOTS)
   ) u_hash (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_accept),
      .in_key   (key_masked),
      .out_valid(home_valid),
      .out_home (home)
   );

   lpht_store #(
      .SLOTS (SLOTS),
      .KEY_W (KEY_W)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .clear_busy(clear_busy),
      .rd_addr   (rd_addr),
      .rd_key    (rd_key),
      .rd_mark   (rd_mark),
      .wr_addr   (probe_idx_ff),
      .wr        (wr),
      .wr_key    (key_ff)
   );

   // Decode of the slot just read (rd_* belongs to probe_idx_ff)
   assign is_insert = (cmd_ff == CMD_INSERT);
   assign is_lookup = (cmd_ff == CMD_FIND) || (cmd_ff == CMD_DELETE);
   assign bad_cmd   = !is_insert && !is_lookup;
   assign ins_hit   = is_insert && (rd_mark != MARK_USED);
   assign lk_hit    = is_lookup && (rd_mark == MARK_USED) && (rd_key == key_ff);
   assign lk_miss   = is_lookup && (rd_mark == MARK_EMPTY);
   assign last_step = (step_ff == LAST_IDX);

   // Narrow output fields wrap for large tables
   assign slot_ext = {{SLOT_INDEX_W{1'b0}}, probe_idx_ff};
   assign step_ext = {{PROBE_COUNT_W{1'b0}}, step_ff};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      probe_idx_in = probe_idx_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      rd_addr      = probe_idx_ff;
      wr           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = req_bus.cmd;
               key_in   = key_masked[KEY_W-1:0];
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (home_valid) begin
               rd_addr      = home;
               probe_idx_in = home;
               step_in      = '0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            // While the output register is occupied, keep re-reading this slot
            if (!out_busy) begin
               if (ins_hit || lk_hit) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_OK;
                  slot_in      = slot_ext[SLOT_INDEX_W-1:0];
                  count_in     = step_ext[PROBE_COUNT_W-1:0];
                  state_in     = ST_IDLE;
                  if (is_insert) begin
                     wr.key_we  = 1'b1;
                     wr.mark_we = 1'b1;
                     wr.mark    = MARK_USED;
                  end else if (cmd_ff == CMD_DELETE) begin
                     wr.mark_we = 1'b1;
                     wr.mark    = MARK_TOMB;
                  end
               end else if (lk_miss || bad_cmd) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_MISS;
                  slot_in      = '0;
                  count_in     = step_ext[PROBE_COUNT_W-1:0];
                  state_in     = ST_IDLE;
               end else if (last_step) begin
                  // Every slot visited
                  rsp_valid_in = 1'b1;
                  status_in    = is_insert ? ST_FULL : ST_MISS;
                  slot_in      = '0;
                  count_in     = FULL_COUNT;
                  state_in     = ST_IDLE;
               end else begin
                  probe_idx_in = (probe_idx_ff == LAST_IDX) ? '0 : probe_idx_ff + IDX_W'(1);
                  step_in      = step_ff + IDX_W'(1);
                  rd_addr      = probe_idx_in;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      probe_idx_ff <= probe_idx_in;
      step_ff      <= step_in;
      status_ff    <= status_in;
      slot_ff      <= slot_in;
      count_ff     <= count_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.slot_index  = slot_ff;
   assign rsp_bus.probe_count = count_ff;

   // Checks

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_accept)
      else $error("request beat accepted during mark sweep");

   a_home_only_in_hash: assert property (@(posedge clock) disable iff (reset)
      home_valid |-> (state_ff == ST_HASH))
      else $error("home slot arrived outside hash wait");

   a_stall_holds_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) && out_busy |=> $stable(probe_idx_ff) && $stable(step_ff))
      else $error("probe advanced while output register busy");

   a_write_on_finish: assert property (@(posedge clock) disable iff (reset)
      (wr.key_we || wr.mark_we) |-> (state_ff == ST_PROBE) && !out_busy
                                    && (state_in == ST_IDLE))
      else $error("slot write outside a finishing probe");

   a_finish_gives_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) && (state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("probe finished without a response beat");

endmodule

[rtl/lpht_hash.sv]
// Home slot unit: key modulo SLOTS by reciprocal multiply and one correction.
// Two register stages. Depends on lpht_pkg.
module lpht_hash import lpht_pkg::*; #(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [KEY_IN_W-1:0]        in_key,
   output logic                       out_valid,
   output logic [$clog2(SLOTS)-1:0]   out_home
);

   localparam int IDX_W   = $clog2(SLOTS);
   localparam int SHIFT   = KEY_IN_W + IDX_W;
   localparam int RECIP_W = KEY_IN_W + 1;
   localparam int PROD_W  = KEY_IN_W + RECIP_W;
   localparam logic [63:0]        RECIP_FULL = (64'd1 << SHIFT) / 64'(SLOTS);
   localparam logic [RECIP_W-1:0] RECIP      = RECIP_FULL[RECIP_W-1:0];
   localparam logic [IDX_W:0]     SLOTS_C    = (IDX_W+1)'(SLOTS);

   logic [PROD_W-1:0]    prod;
   logic [IDX_W:0]       qlo_ff, qlo_in;
   logic [IDX_W:0]       keylo_ff, keylo_in;
   logic                 s1_valid_ff, s2_valid_ff;
   logic [2*IDX_W+1:0]   qs_prod;
   logic [IDX_W:0]       rem0, rem;
   logic [IDX_W-1:0]     home_ff, home_in;

   // Stage 1: quotient estimate, low bits only (it is q or q-1)
   assign prod     = PROD_W'(in_key) * PROD_W'(RECIP);
   assign qlo_in   = prod[SHIFT+IDX_W:SHIFT];
   assign keylo_in = in_key[IDX_W:0];

   // Stage 2: remainder below 2*SLOTS, one conditional subtract
   assign qs_prod = (2*IDX_W+2)'(qlo_ff) * (2*IDX_W+2)'(SLOTS_C);
   assign rem0    = keylo_ff - qs_prod[IDX_W:0];
   assign rem     = (rem0 >= SLOTS_C) ? (rem0 - SLOTS_C) : rem0;
   assign home_in = rem[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      qlo_ff   <= qlo_in;
      keylo_ff <= keylo_in;
      home_ff  <= home_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_home  = home_ff;

endmodule

[rtl/lpht_store.sv]
// Slot store: key memory and mark memory, one read and one write port each,
// registered read data, mark clearing pass after reset. Depends on lpht_pkg.
module lpht_store import lpht_pkg::*; #(
   parameter int SLOTS = DEF_SLOTS,
   parameter int KEY_W = DEF_KEY_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     clear_busy,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output logic [KEY_W-1:0]         rd_key,
   output logic [MARK_W-1:0]        rd_mark,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  lpht_wr_type              wr,
   input  logic [KEY_W-1:0]         wr_key
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [KEY_W-1:0]  key_mem  [SLOTS];
   logic [MARK_W-1:0] mark_mem [SLOTS];

   logic             clearing_ff, clearing_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic [KEY_W-1:0]  rd_key_ff;
   logic [MARK_W-1:0] rd_mark_ff;

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == LAST_IDX) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // Keys: never cleared
   always_ff @(posedge clock) begin
      if (wr.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   // Marks: swept to empty after reset
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mark_mem[clr_idx_ff] <= MARK_EMPTY;
      end else if (wr.mark_we) begin
         mark_mem[wr_addr] <= wr.mark;
      end
      rd_mark_ff <= mark_mem[rd_addr];
   end

   assign clear_busy = clearing_ff;
   assign rd_key     = rd_key_ff;
   assign rd_mark    = rd_mark_ff;

endmodule

[tb/linear_probe_hash_table_tb.sv]
// Self-checking testbench for linear_probe_hash_table: directed then random insert,
// find and delete beats, checked against a predictor held in a scoreboard class.
// Depends on lpht_pkg, lpht_if and the linear_probe_hash_table RTL.
module linear_probe_hash_table_tb import lpht_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_COUNT   = DEF_SLOTS;
   localparam int POOL_SIZE    = 24;   // reused keys, so finds and deletes mostly hit
   localparam int RANDOM_ITEMS = 1700;
   localparam int IDLE_PCT     = 21;
   localparam int HOLDOFF_AT   = 400;  // commands taken before the long response stall
   localparam int HOLDOFF_LEN  = 300;
   localparam int STALL_LIMIT  = 4000; // cycles with no beat on either channel
   localparam int DRAIN_CYCLES = SLOT_COUNT + 12;

   // cmd 3 has no meaning in the block, it must answer a plain miss
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [SLOT_INDEX_W-1:0]  slot_index;
      logic [PROBE_COUNT_W-1:0] probe_count;
   } probe_answer_type;

   // ------------------------------------------------------------------
   // Scoreboard: shadow copy of the slot store plus the answers in flight.
   // ------------------------------------------------------------------
   class slot_table_tracker;
      logic [KEY_IN_W-1:0] keys  [SLOT_COUNT];
      logic [MARK_W-1:0]   marks [SLOT_COUNT];
      probe_answer_type    answers_due [$];
      int unsigned         mismatches, answers_seen, full_seen, miss_seen, deepest;
      int unsigned         taken, n_insert, n_find, n_delete, n_unused;

      function new();
         foreach (marks[i]) marks[i] = MARK_EMPTY;
         mismatches = 0; answers_seen = 0; full_seen = 0; miss_seen = 0; deepest = 0;
         taken = 0; n_insert = 0; n_find = 0; n_delete = 0; n_unused = 0;
      endfunction

      // Walks the shadow table exactly as the block should, updating it
      function probe_answer_type walk_table(logic [CMD_W-1:0] cmd,
                                            logic [KEY_IN_W-1:0] key);
         int unsigned      idx, step;
         bit               done;
         probe_answer_type ans;
         idx  = key % SLOT_COUNT;
         step = 0;
         done = 0;
         ans.status      = ST_MISS;
         ans.slot_index  = '0;
         ans.probe_count = '0;
         if (cmd == CMD_INSERT) begin
            while (!done && step < SLOT_COUNT) begin
               if (marks[idx] != MARK_USED) begin
                  keys[idx]       = key;
                  marks[idx]      = MARK_USED;
                  ans.status      = ST_OK;
                  ans.slot_index  = idx[SLOT_INDEX_W-1:0];
                  ans.probe_count = step[PROBE_COUNT_W-1:0];
                  done            = 1;
               end else begin
                  idx = (idx + 1) % SLOT_COUNT;
                  step++;
               end
            end
            if (!done) begin
               ans.status      = ST_FULL;
               ans.probe_count = step[PROBE_COUNT_W-1:0];
            end
         end else if (cmd == CMD_FIND || cmd == CMD_DELETE) begin
            while (!done && step < SLOT_COUNT) begin
               if (marks[idx] == MARK_EMPTY) begin
                  ans.probe_count = step[PROBE_COUNT_W-1:0];
                  done            = 1;
               end else if (marks[idx] == MARK_USED && keys[idx] == key) begin
                  if (cmd == CMD_DELETE) marks[idx] = MARK_TOMB;
                  ans.status      = ST_OK;
                  ans.slot_index  = idx[SLOT_INDEX_W-1:0];
                  ans.probe_count = step[PROBE_COUNT_W-1:0];
                  done            = 1;
               end else begin
                  idx = (idx + 1) % SLOT_COUNT;
                  step++;
               end
            end
            // all slots visited without reaching an empty one
            if (!done) ans.probe_count = step[PROBE_COUNT_W-1:0];
         end
         return ans;
      endfunction

      function void take_command(logic [CMD_W-1:0] cmd, logic [KEY_IN_W-1:0] key);
         taken++;
         case (cmd)
            CMD_INSERT: n_insert++;
            CMD_FIND:   n_find++;
            CMD_DELETE: n_delete++;
            default:    n_unused++;
         endcase
         answers_due.push_back(walk_table(cmd, key));
      endfunction

      task report(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task match_answer(logic [STATUS_W-1:0] status, logic [SLOT_INDEX_W-1:0] slot,
                        logic [PROBE_COUNT_W-1:0] probes);
         probe_answer_type want;
         answers_seen++;
         if (answers_due.size() == 0) begin
            report($sformatf("response beat with no command outstanding (st %0d slot %0d pr %0d)",
                             status, slot, probes));
         end else begin
            want = answers_due.pop_front();
            if (want.status == ST_FULL) full_seen++;
            if (want.status == ST_MISS) miss_seen++;
            if (want.probe_count > deepest) deepest = want.probe_count;
            if (status !== want.status)
               report($sformatf("status %0d, expected %0d", status, want.status));
            if (slot !== want.slot_index)
               report($sformatf("slot_index %0d, expected %0d", slot, want.slot_index));
            if (probes !== want.probe_count)
               report($sformatf("probe_count %0d, expected %0d", probes, want.probe_count));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   bit   quiet;   // no idling on either side while set

   slot_table_tracker tracker;
   logic [KEY_IN_W-1:0] key_pool [POOL_SIZE];

   lpht_req_if req_bus ();
   lpht_rsp_if rsp_bus ();

   linear_probe_hash_table #(
      .SLOTS    (SLOT_COUNT),
      .KEY_BITS (DEF_KEY_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Monitor. Everything is sampled in the active region of the rising
   // edge, before any nonblocking update lands, so each beat is seen with
   // the values that made the handshake. Commands are noted first, then
   // the response beat of the same edge (if any) is checked.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.take_command(req_bus.cmd, req_bus.key);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.match_answer(rsp_bus.status, rsp_bus.slot_index, rsp_bus.probe_count);
      end
   end

   // Watchdog: a run that stops moving beats for too long is a hang
   int unsigned stall_cycles;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles, %0d answers outstanding",
                     $realtime, STALL_LIMIT, tracker.answers_due.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response side. Random backpressure, none in the quiet stretch, and
   // one long hold-off once enough commands have gone in: the block
   // keeps one item in flight plus one in its output register, so the
   // request side stalls behind it.
   // ------------------------------------------------------------------
   initial begin
      int unsigned hold_left;
      bit          held;
      logic        take;
      hold_left = 0;
      held      = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && tracker != null && tracker.taken >= HOLDOFF_AT) begin
            held      = 1;
            hold_left = HOLDOFF_LEN;
         end
         if (reset)
            take = 1'b0;
         else if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (quiet)
            take = 1'b1;
         else
            take = ($urandom_range(0, 99) >= IDLE_PCT);
         rsp_bus.ready <= take;
      end
   end

   // One request beat: random idle cycles first, then hold valid until taken.
   // Called right after an edge, so valid gets exactly one assignment per step.
   task send_command(logic [CMD_W-1:0] cmd, logic [KEY_IN_W-1:0] key);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= cmd;
      req_bus.key   <= key;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Directed: corner keys, collisions with wrap, tombstone skip and reuse,
   // misses, the unused command, then a full table.
   task run_corner_cases();
      send_command(CMD_UNUSED, 32'hFFFF_FFFF);
      send_command(CMD_FIND,   32'h0000_0000);   // empty table, miss at home slot
      send_command(CMD_INSERT, 32'h0000_0000);
      send_command(CMD_INSERT, 32'h0000_0010);   // same home, one step on
      send_command(CMD_INSERT, 32'hFFFF_FFFF);   // home is the last slot
      send_command(CMD_INSERT, 32'h0000_001F);   // wraps past slot 0 and 1
      send_command(CMD_FIND,   32'h0000_0010);
      send_command(CMD_DELETE, 32'h0000_0000);   // leaves a tombstone at slot 0
      send_command(CMD_FIND,   32'h0000_0010);   // must walk over the tombstone
      send_command(CMD_DELETE, 32'h0001_2345);   // absent
      send_command(CMD_INSERT, 32'h0000_0020);   // reuses the tombstone
      for (int i = 0; i < SLOT_COUNT - 4; i++)
         send_command(CMD_INSERT, 32'h5A00_0003 + i * 32'h0101_0013);
      send_command(CMD_INSERT, 32'h8000_0007);   // table full
      send_command(CMD_FIND,   32'h7FFF_FFF8);   // full walk, no empty slot
      send_command(CMD_DELETE, 32'hC0DE_0001);
   endtask

   // Random mix over a small key pool clustered around the wrap point, so
   // chains collide, run long and pass tombstones. Insert weight swings
   // every 200 items to move the table between nearly empty and full.
   task run_random_mix(int count);
      int unsigned      roll, insert_pct;
      logic [CMD_W-1:0] cmd;
      logic [KEY_IN_W-1:0] key;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i]      = $urandom();
         key_pool[i][3:0] = 4'($urandom_range(12, 19) % SLOT_COUNT);
      end
      for (int n = 0; n < count; n++) begin
         quiet      = (n >= 800 && n < 1100);
         insert_pct = ((n / 200) % 2) ? 50 : 28;
         roll       = $urandom_range(0, 99);
         if (roll < 3)
            cmd = CMD_UNUSED;
         else if (roll < 3 + insert_pct)
            cmd = CMD_INSERT;
         else if (roll < (103 + insert_pct) / 2)
            cmd = CMD_FIND;
         else
            cmd = CMD_DELETE;
         if ($urandom_range(0, 99) < 18)
            key = $urandom();
         else
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         send_command(cmd, key);
      end
      quiet = 0;
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      tracker = new();
      quiet   = 0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd   <= CMD_INSERT;
      req_bus.key   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // the mark sweep after reset simply shows up as ready held low
      run_corner_cases();
      run_random_mix(RANDOM_ITEMS);
      req_bus.valid <= 1'b0;

      while (tracker.answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      // anything still owed after the drain is a lost response
      if (tracker.answers_due.size() != 0)
         tracker.report($sformatf("%0d response beats never arrived",
                                  tracker.answers_due.size()));

      $display("covered %0d commands: %0d insert, %0d find, %0d delete, %0d unused code",
               tracker.taken, tracker.n_insert, tracker.n_find, tracker.n_delete,
               tracker.n_unused);
      $display("%0d answers checked: %0d full table, %0d miss, longest walk %0d, %0d mismatches",
               tracker.answers_seen, tracker.full_seen, tracker.miss_seen, tracker.deepest,
               tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
